[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the pedal sensor calibration block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PSCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pscs: assertion failed");
// Expression must never be true at a clock edge outside reset.
`define PSCS_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("pscs: forbidden condition seen");
`else
`define PSCS_ASSERT(lbl, clk, rstn, prop)
`define PSCS_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif

`endif

[rtl/pscs_pkg.sv]
// Package with types and constants of the pedal sensor calibration block.
package pscs_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int WORD_W          = 16;
  localparam int ELAPSED_W       = 20;
  localparam int SECS_W          = 8;
  localparam int TIMER_W         = 28;
  localparam int FRAC_BITS       = 15;
  localparam int CFG_IDX_W       = 2;
  localparam int MARGIN_W        = 11;
  localparam int CNT_W           = 4;

  localparam logic [WORD_W-1:0] DEFAULT_LOW_RST  = 16'd550;
  localparam logic [WORD_W-1:0] DEFAULT_HIGH_RST = 16'd1250;

  localparam logic [MARGIN_W-1:0] MARGIN_UP   = 11'd1045;
  localparam logic [MARGIN_W-1:0] MARGIN_DOWN = 11'd973;

  localparam logic [WORD_W-1:0] FULL_Q       = 16'd32768;
  localparam logic [WORD_W-1:0] LIGHT_Q_20   = 16'd6554;
  localparam logic [WORD_W-1:0] LIGHT_Q_30   = 16'd9830;
  localparam logic [WORD_W-1:0] KNEE_Q_02    = 16'd655;
  localparam logic [WORD_W-1:0] KNEE_Q_30    = 16'd9830;

  localparam logic [ELAPSED_W-1:0] US_PER_SEC = 20'd1000000;
  localparam logic [TIMER_W-1:0]   TIMER_MAX  = {TIMER_W{1'b1}};

  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS - 1);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BENCH_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_HIGH = 2'd3;

  localparam logic MODE_LOOP  = 1'b0;
  localparam logic MODE_START = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN,
    ST_DIFF,
    ST_DIV,
    ST_CAL,
    ST_SCALE_LO,
    ST_SCALE_HI,
    ST_DONE
  } state_e;

endpackage

[rtl/pscs_ifs.sv]
// Handshake channel interfaces of the pedal sensor calibration block.
interface pscs_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic [pscs_pkg::WORD_W-1:0]           sample;
  logic [pscs_pkg::ELAPSED_W-1:0]        elapsed_us;
  logic [pscs_pkg::SECS_W-1:0]           run_seconds;

  modport source (output valid, mode, sample, elapsed_us, run_seconds, input ready);
  modport sink   (input valid, mode, sample, elapsed_us, run_seconds, output ready);
endinterface

interface pscs_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [pscs_pkg::WORD_W-1:0]           fraction;
  logic [pscs_pkg::WORD_W-1:0]           light_level;
  logic                                  calibrating;
  logic [pscs_pkg::WORD_W-1:0]           bound_low;
  logic [pscs_pkg::WORD_W-1:0]           bound_high;

  modport source (output valid, fraction, light_level, calibrating, bound_low, bound_high,
                  input ready);
  modport sink   (input valid, fraction, light_level, calibrating, bound_low, bound_high,
                  output ready);
endinterface

interface pscs_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [pscs_pkg::CFG_IDX_W-1:0]        index;
  logic [pscs_pkg::WORD_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/pedal_sensor_calibrate_and_scale_top.sv]
// Top level of the pedal sensor min/max calibration and normalization block.
//
// Channels: in_i takes one word per control loop pass. A loop word (mode 0)
// carries a raw pressure sample and the microseconds since the previous
// word; a start word (mode 1) opens a calibration window of run_seconds.
// out_o gives one result word per loop word: the Q1.15 pedal fraction, the
// brake light level, the window flag and the bounds after this word. Start
// words give no result. cfg_i writes the four configuration registers and
// is always ready; the user must write it only while the block is idle.
// The block itself does not enforce this. A start word is absorbed in the
// cycle it is accepted. A loop word passes the span, difference, divide,
// calibrate, margin and done states, skipping those it does not need,
// before its result sits in the output register; the restoring divider
// takes 15 steps, one quotient bit per cycle through the shared subtractor,
// and the two margin products share one multiplier. in_i is ready only
// while the sequencer is idle, so no word is taken while a loop word runs.
// Reset: the bounds return to 550 and 1250, the block counts as calibrated,
// the window is closed and the registers take their reset values.
// Stall: a finished result waits in the output register; the sequencer
// holds its next result until that register is free, and a new word may
// be accepted while the previous result still waits.
`include "assert_macros.svh"

module pedal_sensor_calibrate_and_scale_top #(
  parameter int SAMPLE_BITS = pscs_pkg::SAMPLE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pscs_in_if.sink    in_i,
  pscs_out_if.source out_o,
  pscs_cfg_if.sink   cfg_i
);

  localparam int W  = pscs_pkg::WORD_W;
  localparam int TW = pscs_pkg::TIMER_W;
  localparam int PW = pscs_pkg::WORD_W + pscs_pkg::MARGIN_W;
  localparam logic [W-1:0] SAMPLE_MASK = W'((32'd1 << SAMPLE_BITS) - 32'd1);

  // Light level from the fraction; bench mode grades the low end.
  function automatic logic [W-1:0] light_for(input logic [W-1:0] f, input logic bench);
    logic [W-1:0] lv;
    if (f == '0) begin
      lv = '0;
    end else if (!bench) begin
      lv = pscs_pkg::FULL_Q;
    end else if (f <= pscs_pkg::KNEE_Q_02) begin
      lv = pscs_pkg::LIGHT_Q_20;
    end else if (f <= pscs_pkg::KNEE_Q_30) begin
      lv = pscs_pkg::LIGHT_Q_30;
    end else begin
      lv = f;
    end
    return lv;
  endfunction

  pscs_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic         bench_q, bench_d;
  logic         rev_q, rev_d;
  logic [W-1:0] dflt_low_q, dflt_low_d;
  logic [W-1:0] dflt_high_q, dflt_high_d;

  // Calibration state.
  logic          open_q, open_d;
  logic          cal_q, cal_d;
  logic [W-1:0]  low_q, low_d;
  logic [W-1:0]  high_q, high_d;
  logic [TW-1:0] timer_q, timer_d;
  logic [TW-1:0] limit_q, limit_d;

  // Working registers of the sequencer.
  logic [W-1:0]                    samp_q, samp_d;
  logic [W-1:0]                    span_q, span_d;
  logic [W-1:0]                    rem_q, rem_d;
  logic [pscs_pkg::FRAC_BITS-1:0]  quot_q, quot_d;
  logic [pscs_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [W-1:0]                    frac_q, frac_d;

  // Output register.
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] out_frac_q, out_frac_d;
  logic [W-1:0] out_light_q, out_light_d;
  logic         out_cal_q, out_cal_d;
  logic [W-1:0] out_low_q, out_low_d;
  logic [W-1:0] out_high_q, out_high_d;

  logic in_fire, out_fire, cfg_fire, out_free;
  logic [W-1:0] samp_in;

  // Shared subtractor.
  logic [W:0]   alu_a, alu_b;
  logic [W+1:0] alu_diff;
  logic         alu_borrow;
  logic [W:0]   alu_res;

  // Shared margin multiplier.
  logic [W-1:0]                  mul_a;
  logic [pscs_pkg::MARGIN_W-1:0] mul_f;
  logic [PW-1:0]                 mul_p;
  logic [W:0]                    mul_scaled;
  logic [W-1:0]                  mul_sat;

  logic [TW:0]   timer_sum;
  logic [TW-1:0] limit_new;

  assign in_i.ready  = (state_q == pscs_pkg::ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign out_fire    = out_valid_q && out_o.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign samp_in     = in_i.sample & SAMPLE_MASK;

  assign out_o.valid       = out_valid_q;
  assign out_o.fraction    = out_frac_q;
  assign out_o.light_level = out_light_q;
  assign out_o.calibrating = out_cal_q;
  assign out_o.bound_low   = out_low_q;
  assign out_o.bound_high  = out_high_q;

  // Subtractor operand selection.
  always_comb begin
    case (state_q)
      pscs_pkg::ST_SPAN: begin
        alu_a = {1'b0, high_q};
        alu_b = {1'b0, low_q};
      end
      pscs_pkg::ST_DIFF: begin
        alu_a = {1'b0, samp_q};
        alu_b = {1'b0, low_q};
      end
      default: begin
        alu_a = {rem_q, 1'b0};
        alu_b = {1'b0, span_q};
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[W+1];
  assign alu_res    = alu_diff[W:0];

  // Margin multiplier: low bound in ST_SCALE_LO, high bound in the ST_SCALE_HI state that follows.
  always_comb begin
    if (state_q == pscs_pkg::ST_SCALE_HI) begin
      mul_a = high_q;
      mul_f = rev_q ? pscs_pkg::MARGIN_UP : pscs_pkg::MARGIN_DOWN;
    end else begin
      mul_a = low_q;
      mul_f = rev_q ? pscs_pkg::MARGIN_DOWN : pscs_pkg::MARGIN_UP;
    end
  end

  assign mul_p      = PW'(mul_a) * PW'(mul_f);
  assign mul_scaled = mul_p[PW-1:10];
  assign mul_sat    = mul_scaled[W] ? {W{1'b1}} : mul_scaled[W-1:0];

  assign timer_sum = {1'b0, timer_q} + (TW+1)'(in_i.elapsed_us);
  assign limit_new = TW'(in_i.run_seconds) * TW'(pscs_pkg::US_PER_SEC);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pscs_pkg::ST_IDLE: begin
        if (in_fire && (in_i.mode == pscs_pkg::MODE_LOOP)) begin
          state_d = pscs_pkg::ST_SPAN;
        end
      end
      pscs_pkg::ST_SPAN: begin
        if (open_q || !cal_q || alu_borrow || (alu_res == '0)) begin
          state_d = pscs_pkg::ST_CAL;
        end else begin
          state_d = pscs_pkg::ST_DIFF;
        end
      end
      pscs_pkg::ST_DIFF: begin
        if (alu_borrow || (alu_res == '0) || (samp_q >= high_q)) begin
          state_d = pscs_pkg::ST_CAL;
        end else begin
          state_d = pscs_pkg::ST_DIV;
        end
      end
      pscs_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = pscs_pkg::ST_CAL;
        end
      end
      pscs_pkg::ST_CAL: begin
        if (!open_q || (timer_q < limit_q)) begin
          state_d = pscs_pkg::ST_DONE;
        end else begin
          state_d = pscs_pkg::ST_SCALE_LO;
        end
      end
      pscs_pkg::ST_SCALE_LO: state_d = pscs_pkg::ST_SCALE_HI;
      pscs_pkg::ST_SCALE_HI: state_d = pscs_pkg::ST_DONE;
      pscs_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = pscs_pkg::ST_IDLE;
        end
      end
      default: state_d = pscs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    bench_d     = bench_q;
    rev_d       = rev_q;
    dflt_low_d  = dflt_low_q;
    dflt_high_d = dflt_high_q;
    open_d      = open_q;
    cal_d       = cal_q;
    low_d       = low_q;
    high_d      = high_q;
    timer_d     = timer_q;
    limit_d     = limit_q;
    samp_d      = samp_q;
    span_d      = span_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    cnt_d       = cnt_q;
    frac_d      = frac_q;
    out_valid_d = out_valid_q && !out_fire;
    out_frac_d  = out_frac_q;
    out_light_d = out_light_q;
    out_cal_d   = out_cal_q;
    out_low_d   = out_low_q;
    out_high_d  = out_high_q;

    if (cfg_fire) begin
      case (cfg_i.index)
        pscs_pkg::REG_BENCH_MODE:   bench_d     = cfg_i.data[0];
        pscs_pkg::REG_REVERSE:      rev_d       = cfg_i.data[0];
        pscs_pkg::REG_DEFAULT_LOW:  dflt_low_d  = cfg_i.data;
        pscs_pkg::REG_DEFAULT_HIGH: dflt_high_d = cfg_i.data;
        default: ;
      endcase
    end

    case (state_q)
      pscs_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_i.mode == pscs_pkg::MODE_START) begin
            // A start word during an open window only restarts its timer.
            if (!open_q) begin
              open_d  = 1'b1;
              cal_d   = 1'b0;
              low_d   = dflt_low_q;
              high_d  = dflt_high_q;
              limit_d = limit_new;
            end
            timer_d = '0;
          end else begin
            samp_d = samp_in;
            frac_d = '0;
            if (open_q) begin
              timer_d = timer_sum[TW] ? pscs_pkg::TIMER_MAX : timer_sum[TW-1:0];
            end
          end
        end
      end
      pscs_pkg::ST_SPAN: begin
        span_d = alu_res[W-1:0];
      end
      pscs_pkg::ST_DIFF: begin
        rem_d = alu_res[W-1:0];
        cnt_d = pscs_pkg::DIV_LAST;
        if (!alu_borrow && (alu_res != '0) && (samp_q >= high_q)) begin
          frac_d = pscs_pkg::FULL_Q;
        end
      end
      pscs_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_d  = alu_borrow ? alu_a[W-1:0] : alu_res[W-1:0];
        quot_d = {quot_q[pscs_pkg::FRAC_BITS-2:0], !alu_borrow};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          frac_d = {1'b0, quot_q[pscs_pkg::FRAC_BITS-2:0], !alu_borrow};
        end
      end
      pscs_pkg::ST_CAL: begin
        if (open_q && (timer_q < limit_q)) begin
          if (samp_q < low_q) begin
            low_d = samp_q;
          end
          if (samp_q > high_q) begin
            high_d = samp_q;
          end
        end
      end
      pscs_pkg::ST_SCALE_LO: begin
        low_d = mul_sat;
      end
      pscs_pkg::ST_SCALE_HI: begin
        high_d = mul_sat;
        open_d = 1'b0;
        cal_d  = 1'b1;
      end
      pscs_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_frac_d  = frac_q;
          out_light_d = light_for(frac_q, bench_q);
          out_cal_d   = open_q;
          out_low_d   = low_q;
          out_high_d  = high_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pscs_pkg::ST_IDLE;
      bench_q     <= 1'b0;
      rev_q       <= 1'b0;
      dflt_low_q  <= pscs_pkg::DEFAULT_LOW_RST;
      dflt_high_q <= pscs_pkg::DEFAULT_HIGH_RST;
      open_q      <= 1'b0;
      cal_q       <= 1'b1;
      low_q       <= pscs_pkg::DEFAULT_LOW_RST;
      high_q      <= pscs_pkg::DEFAULT_HIGH_RST;
      timer_q     <= '0;
      limit_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bench_q     <= bench_d;
      rev_q       <= rev_d;
      dflt_low_q  <= dflt_low_d;
      dflt_high_q <= dflt_high_d;
      open_q      <= open_d;
      cal_q       <= cal_d;
      low_q       <= low_d;
      high_q      <= high_d;
      timer_q     <= timer_d;
      limit_q     <= limit_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    samp_q      <= samp_d;
    span_q      <= span_d;
    rem_q       <= rem_d;
    quot_q      <= quot_d;
    frac_q      <= frac_d;
    out_frac_q  <= out_frac_d;
    out_light_q <= out_light_d;
    out_cal_q   <= out_cal_d;
    out_low_q   <= out_low_d;
    out_high_q  <= out_high_d;
  end

  `PSCS_ASSERT(a_frac_max, clk_i, rst_ni, out_valid_q |-> (out_frac_q <= pscs_pkg::FULL_Q))
  `PSCS_ASSERT(a_light_zero, clk_i, rst_ni, out_valid_q |-> ((out_frac_q == '0) == (out_light_q == '0)))
  `PSCS_ASSERT(a_open_no_frac, clk_i, rst_ni, (out_valid_q && out_cal_q) |-> (out_frac_q == '0))
  `PSCS_ASSERT(a_div_rem, clk_i, rst_ni, (state_q == pscs_pkg::ST_DIV) |-> (rem_q < span_q))
  `PSCS_ASSERT_NEVER(a_cal_vs_open, clk_i, rst_ni, cal_q == open_q)

endmodule

[tb/tb.sv]
// Self-checking testbench for the pedal sensor calibration and scaling block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pscs_pkg::*;

  // The settle time lets the last loop word finish and leaves the block idle.
  localparam int SETTLE_CYCLES   = 40;
  localparam int QUIET_LIMIT     = 1000;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 135;

  typedef struct packed {
    logic                 mode;
    logic [WORD_W-1:0]    sample;
    logic [ELAPSED_W-1:0] elapsed_us;
    logic [SECS_W-1:0]    run_seconds;
  } pedal_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] fraction;
    logic [WORD_W-1:0] light_level;
    logic              calibrating;
    logic [WORD_W-1:0] bound_low;
    logic [WORD_W-1:0] bound_high;
  } pedal_reading_t;

  // One row of the directed script. Where typed is set, the reading in the row is the
  // one awaited; otherwise the reading comes from the calibration model below.
  typedef struct packed {
    pedal_word_t    word;
    logic           typed;
    pedal_reading_t reading;
  } script_row_t;

  localparam int SCRIPT_ROWS = 20;

  // The script starts from the reset configuration: full-on light, no reversal and
  // bounds of 550 and 1250. It walks the field extremes, a zero-length window that
  // closes without widening, a restart inside an open window, and the margins.
  script_row_t script [SCRIPT_ROWS] = '{
    // Sample at zero and at the low bound give no fraction and no light.
    '{'{MODE_LOOP, 16'd0, 20'd0, 8'd0}, 1'b1, '{16'd0, 16'd0, 1'b0, 16'd550, 16'd1250}},
    '{'{MODE_LOOP, 16'd550, 20'd1000, 8'd0}, 1'b1,
      '{16'd0, 16'd0, 1'b0, 16'd550, 16'd1250}},
    // At and far above the high bound the fraction clamps to full scale.
    '{'{MODE_LOOP, 16'd1250, 20'd0, 8'd0}, 1'b1,
      '{16'd32768, 16'd32768, 1'b0, 16'd550, 16'd1250}},
    '{'{MODE_LOOP, 16'd65535, 20'hFFFFF, 8'd255}, 1'b1,
      '{16'd32768, 16'd32768, 1'b0, 16'd550, 16'd1250}},
    '{'{MODE_LOOP, 16'd900, 20'd12345, 8'd0}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd551, 20'd0, 8'd0}, 1'b0, '0},
    // Zero-length window: the next loop word closes it and applies the margins.
    '{'{MODE_START, 16'd0, 20'hFFFFF, 8'd0}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd65535, 20'd0, 8'd0}, 1'b1, '{16'd0, 16'd0, 1'b0, 16'd561, 16'd1187}},
    '{'{MODE_LOOP, 16'd1187, 20'd0, 8'd0}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd874, 20'd0, 8'd0}, 1'b0, '0},
    // One-second window: widen low, restart the timer, widen high, then close.
    '{'{MODE_START, 16'd0, 20'd0, 8'd1}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd100, 20'd500000, 8'd0}, 1'b1,
      '{16'd0, 16'd0, 1'b1, 16'd100, 16'd1250}},
    '{'{MODE_START, 16'd40000, 20'hFFFFF, 8'd200}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd65535, 20'd999999, 8'd0}, 1'b1,
      '{16'd0, 16'd0, 1'b1, 16'd100, 16'd65535}},
    '{'{MODE_LOOP, 16'd3000, 20'd1, 8'd0}, 1'b1,
      '{16'd0, 16'd0, 1'b0, 16'd102, 16'd62271}},
    '{'{MODE_LOOP, 16'd101, 20'd0, 8'd0}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd700, 20'd0, 8'd0}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd20000, 20'd0, 8'd0}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd62271, 20'd0, 8'd0}, 1'b0, '0},
    '{'{MODE_LOOP, 16'd65535, 20'd0, 8'd0}, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  pscs_in_if  in_if ();
  pscs_out_if out_if ();
  pscs_cfg_if cfg_if ();

  pedal_sensor_calibrate_and_scale_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow of the configuration registers.
  logic              bench_on;
  logic              reversed;
  logic [WORD_W-1:0] dflt_lo;
  logic [WORD_W-1:0] dflt_hi;

  // Shadow of the calibration state.
  logic               win_open;
  logic               calibrated;
  logic [WORD_W-1:0]  lo_bound;
  logic [WORD_W-1:0]  hi_bound;
  logic [TIMER_W-1:0] win_timer_us;
  logic [SECS_W-1:0]  win_secs;

  // Readings still owed by the block, oldest first.
  pedal_reading_t pedal_readings [$];

  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned rx_hold;
  int unsigned window_age;
  bit          gaps_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // A bound after its margin, truncated and saturated to 16 bits.
  function automatic logic [WORD_W-1:0] scaled_bound(input logic [WORD_W-1:0] b,
                                                      input logic [MARGIN_W-1:0] factor);
    logic [26:0] prod;
    prod = 27'(b) * 27'(factor);
    prod = prod >> 10;
    return (prod > 27'hFFFF) ? 16'hFFFF : prod[WORD_W-1:0];
  endfunction

  // Moves the calibration state on by one accepted word. A loop word yields the
  // reading that the block has to give for it; a start word yields none.
  task automatic calibrate_and_scale(input pedal_word_t w, output bit has_reading,
                                     output pedal_reading_t r);
    logic [TIMER_W:0]   sum;
    logic [31:0]        span;
    logic [31:0]        quot;
    logic [WORD_W-1:0]  frac;
    logic [WORD_W-1:0]  light;
    has_reading = 1'b0;
    r = '0;
    if (w.mode == MODE_START) begin
      // Inside an open window a start word only restarts the timer.
      if (!win_open) begin
        win_open   = 1'b1;
        lo_bound   = dflt_lo;
        hi_bound   = dflt_hi;
        calibrated = 1'b0;
        win_secs   = w.run_seconds;
        window_age = 0;
      end
      win_timer_us = '0;
    end else begin
      if (win_open) begin
        sum = {1'b0, win_timer_us} + (TIMER_W+1)'(w.elapsed_us);
        win_timer_us = (sum > {1'b0, TIMER_MAX}) ? TIMER_MAX : sum[TIMER_W-1:0];
      end
      if (win_open || !calibrated || hi_bound <= lo_bound || w.sample <= lo_bound) begin
        frac = '0;
      end else begin
        span = 32'(hi_bound - lo_bound);
        quot = (32'(w.sample - lo_bound) << FRAC_BITS) / span;
        frac = (quot > 32'(FULL_Q)) ? FULL_Q : quot[WORD_W-1:0];
      end
      if (frac == '0) begin
        light = '0;
      end else if (!bench_on) begin
        light = FULL_Q;
      end else if (frac <= KNEE_Q_02) begin
        light = LIGHT_Q_20;
      end else if (frac <= KNEE_Q_30) begin
        light = LIGHT_Q_30;
      end else begin
        light = frac;
      end
      if (win_open) begin
        if (32'(win_timer_us) < 32'(win_secs) * 32'(US_PER_SEC)) begin
          if (w.sample < lo_bound) lo_bound = w.sample;
          if (w.sample > hi_bound) hi_bound = w.sample;
        end else begin
          lo_bound   = scaled_bound(lo_bound, reversed ? MARGIN_DOWN : MARGIN_UP);
          hi_bound   = scaled_bound(hi_bound, reversed ? MARGIN_UP : MARGIN_DOWN);
          win_open   = 1'b0;
          calibrated = 1'b1;
        end
      end
      r = '{frac, light, win_open, lo_bound, hi_bound};
      has_reading = 1'b1;
    end
  endtask

  // Offers one word on the input channel, starting at a falling edge and returning at
  // the falling edge after acceptance. The valid line is left high, so back-to-back
  // words without a gap see one assignment per edge.
  task automatic put_word(input pedal_word_t w, input logic typed, input pedal_reading_t r);
    int unsigned    gap;
    bit             has_reading;
    pedal_reading_t model_r;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= w.mode;
    in_if.sample      <= w.sample;
    in_if.elapsed_us  <= w.elapsed_us;
    in_if.run_seconds <= w.run_seconds;
    do @(posedge clk_i); while (!in_if.ready);
    calibrate_and_scale(w, has_reading, model_r);
    if (has_reading) pedal_readings.push_back(typed ? r : model_r);
    @(negedge clk_i);
  endtask

  // Writes one configuration register; the caller lowers valid after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_BENCH_MODE:   bench_on = val[0];
      REG_REVERSE:      reversed = val[0];
      REG_DEFAULT_LOW:  dflt_lo  = val;
      REG_DEFAULT_HIGH: dflt_hi  = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // The receiver lowers ready for a random number of cycles after each result word.
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= rst_ni;
    end
  end

  // Result checking and the watchdog. Outputs are sampled at the rising edge, before
  // the block's registers take their new values.
  always @(posedge clk_i) begin : result_check
    pedal_reading_t want;
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (out_if.valid && out_if.ready) begin
        if (pedal_readings.size() == 0) begin
          $error("result word with no reading pending: fraction %0d", out_if.fraction);
          mismatches++;
        end else begin
          want = pedal_readings.pop_front();
          check_field("fraction", want.fraction, out_if.fraction);
          check_field("light_level", want.light_level, out_if.light_level);
          check_field("calibrating", want.calibrating, out_if.calibrating);
          check_field("bound_low", want.bound_low, out_if.bound_low);
          check_field("bound_high", want.bound_high, out_if.bound_high);
        end
        rx_hold = gaps_on ? $urandom_range(0, 7) : 0;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    pedal_word_t w;
    int          reach;
    int          lo_edge;
    int          hi_edge;
    int unsigned base;

    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = MODE_LOOP;
    in_if.sample      = '0;
    in_if.elapsed_us  = '0;
    in_if.run_seconds = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_BENCH_MODE;
    cfg_if.data       = '0;
    mismatches        = 0;
    quiet_cycles      = 0;
    rx_hold           = 0;
    window_age        = 0;
    gaps_on           = 1'b1;

    // Reset values of the registers and the calibration state.
    bench_on     = 1'b0;
    reversed     = 1'b0;
    dflt_lo      = DEFAULT_LOW_RST;
    dflt_hi      = DEFAULT_HIGH_RST;
    win_open     = 1'b0;
    calibrated   = 1'b1;
    lo_bound     = DEFAULT_LOW_RST;
    hi_bound     = DEFAULT_HIGH_RST;
    win_timer_us = '0;
    win_secs     = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed script under the reset configuration.
    foreach (script[i]) put_word(script[i].word, script[i].typed, script[i].reading);

    for (int phase = 0; phase < PHASES; phase++) begin
      // Registers change only with the block idle: every reading in, then the
      // settle time, since a start word produces no result to wait for.
      in_if.valid <= 1'b0;
      while (pedal_readings.size() != 0) @(negedge clk_i);
      repeat (SETTLE_CYCLES) @(negedge clk_i);

      // Phase 0 turns bench mode on with the reset defaults and phases 1 to 3 hold the
      // register extremes; the rest are random with the low default under the high one.
      case (phase)
        0: begin
          write_reg(REG_BENCH_MODE, 16'd1);
          write_reg(REG_REVERSE, 16'd0);
          write_reg(REG_DEFAULT_LOW, 16'd550);
          write_reg(REG_DEFAULT_HIGH, 16'd1250);
        end
        1: begin
          write_reg(REG_BENCH_MODE, 16'd0);
          write_reg(REG_REVERSE, 16'd1);
          write_reg(REG_DEFAULT_LOW, 16'd0);
          write_reg(REG_DEFAULT_HIGH, 16'hFFFF);
        end
        2: begin
          write_reg(REG_BENCH_MODE, 16'd1);
          write_reg(REG_REVERSE, 16'd1);
          write_reg(REG_DEFAULT_LOW, 16'hFFFF);
          write_reg(REG_DEFAULT_HIGH, 16'd0);
        end
        3: begin
          write_reg(REG_BENCH_MODE, 16'd1);
          write_reg(REG_REVERSE, 16'd0);
          write_reg(REG_DEFAULT_LOW, 16'hFFFF);
          write_reg(REG_DEFAULT_HIGH, 16'hFFFF);
        end
        default: begin
          base = $urandom_range(0, 30000);
          write_reg(REG_BENCH_MODE, 16'($urandom_range(0, 1)));
          write_reg(REG_REVERSE, 16'($urandom_range(0, 1)));
          write_reg(REG_DEFAULT_LOW, 16'(base));
          write_reg(REG_DEFAULT_HIGH, 16'(base + $urandom_range(1, 35000)));
        end
      endcase
      cfg_if.valid <= 1'b0;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // Idling comes in stretches, some of them with no gaps at all.
        if (n % 32 == 0) gaps_on = ($urandom_range(0, 3) != 0);

        w.mode        = MODE_LOOP;
        w.sample      = 16'($urandom_range(0, 65535));
        w.elapsed_us  = 20'($urandom_range(0, 1048575));
        w.run_seconds = 8'($urandom_range(0, 255));
        reach         = win_open ? 2000 : 64;

        if (!win_open) begin
          // Mostly short windows, so that calibration completes often; now and then
          // a long one, which the forced elapsed time below still brings to an end.
          if ($urandom_range(0, 9) == 0) begin
            w.mode        = MODE_START;
            w.run_seconds = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 2));
          end
        end else begin
          window_age++;
          // A restart keeps the open window, so its seconds field is free to roam.
          // Restarts come only early in a window, so that every window still ends.
          if (window_age <= 24 && $urandom_range(0, 19) == 0) begin
            w.mode = MODE_START;
          end else if (window_age > 24) begin
            w.elapsed_us = '1;
          end else if ($urandom_range(0, 1) == 1) begin
            w.elapsed_us = 20'($urandom_range(0, 300000));
          end
        end

        // Most samples land near the bounds so that every light band is reached;
        // the rest span the whole range.
        if (w.mode == MODE_LOOP && $urandom_range(0, 3) != 0) begin
          lo_edge  = (int'(lo_bound) > reach) ? int'(lo_bound) - reach : 0;
          hi_edge  = (int'(hi_bound) + reach > 65535) ? 65535 : int'(hi_bound) + reach;
          w.sample = 16'($urandom_range(lo_edge, hi_edge));
        end

        put_word(w, 1'b0, '0);
      end
    end

    in_if.valid <= 1'b0;
    while (pedal_readings.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && pedal_readings.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/pscs_pkg.sv
rtl/pscs_ifs.sv
rtl/pedal_sensor_calibrate_and_scale_top.sv
tb/tb.sv
